// ===== rtl/upl_pkg.sv =====
package upl_pkg;

  // request codes carried by func
  typedef enum logic [1:0] {
    FUNC_INSERT  = 2'd0,
    FUNC_READ    = 2'd1,
    FUNC_DELETE  = 2'd2,
    FUNC_REFLECT = 2'd3
  } func_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_LVL_RANGE = 3'd4,
    ST_DELETED   = 3'd5,
    ST_NOT_FOUND = 3'd6,
    ST_REFLECTED = 3'd7
  } status_e;

  localparam int VAL_W   = 16;
  localparam int PAIR_W  = 2 * VAL_W;
  localparam int LEVEL_W = 7;
  localparam int POS_W   = 6;
  localparam int CNT_W   = 7;

endpackage

// ===== rtl/upl_ram.sv =====
module upl_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/unique_pair_list_table_top.sv =====
// ordered list of unique (left, right) pairs, up to DEPTH entries, kept in one
// single-port-read, single-port-write ram with registered read. one request word in,
// one result word out, both on valid/stall. insert scans the list and appends if the
// pair is absent and the list is not full; delete scans the same way, then closes the
// gap one entry per cycle; read by 1-based level reads that entry; reflect reverses
// the lower floor(count/2) entries and the upper rest, each in place, stepping through
// check, read lo, read hi, write lo and write hi for each swap. each request ends in a
// done state that moves its result into the output register once that slot is free.
// in_stall_o is high while a request is being worked on; the next word is taken as
// soon as the previous result sits in the output register, even if it is not yet
// taken. there is no clearing pass after reset: entries at or above the count are
// never read.
module unique_pair_list_table_top #(
  parameter int DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request side
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         func_i,
  input  logic signed [15:0] tile_left_i,
  input  logic signed [15:0] tile_right_i,
  input  logic [6:0]         level_i,
  // result side
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic [5:0]         position_o,
  output logic signed [15:0] out_left_o,
  output logic signed [15:0] out_right_o,
  output logic [6:0]         entry_count_o
);

  // address, count and widened helper widths
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > upl_pkg::LEVEL_W) ? CW : upl_pkg::LEVEL_W;
  localparam int PW = (AW > upl_pkg::POS_W) ? AW : upl_pkg::POS_W;

  // sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SRCH    = 4'd1;
  localparam logic [3:0] S_RDLVL   = 4'd2;
  localparam logic [3:0] S_SHIFT   = 4'd3;
  localparam logic [3:0] S_RF_CHK  = 4'd4;
  localparam logic [3:0] S_RF_RDLO = 4'd5;
  localparam logic [3:0] S_RF_RDHI = 4'd6;
  localparam logic [3:0] S_RF_WRLO = 4'd7;
  localparam logic [3:0] S_RF_WRHI = 4'd8;
  localparam logic [3:0] S_DONE    = 4'd9;

  logic [3:0] state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [1:0] func_q, func_d;
  logic [upl_pkg::PAIR_W-1:0] key_q, key_d;

  // walk pointers: scan/shift read index, compare/write index behind it
  logic [CW-1:0] rd_idx_q, rd_idx_d;
  logic          lag_v_q, lag_v_d;
  logic [AW-1:0] lag_idx_q, lag_idx_d;

  // reflect pointers: lo and exclusive end of the current half
  logic [CW-1:0] lo_q, lo_d;
  logic [CW-1:0] end_q, end_d;
  logic          phase_q, phase_d;
  logic [upl_pkg::PAIR_W-1:0] hold_q, hold_d;

  // pending result
  logic [2:0]                res_status_q, res_status_d;
  logic [AW-1:0]             res_pos_q, res_pos_d;
  logic [upl_pkg::VAL_W-1:0] res_left_q, res_left_d;
  logic [upl_pkg::VAL_W-1:0] res_right_q, res_right_d;

  // output register
  logic                      out_valid_q, out_valid_d;
  logic [2:0]                out_status_q, out_status_d;
  logic [5:0]                out_pos_q, out_pos_d;
  logic [upl_pkg::VAL_W-1:0] out_left_q, out_left_d;
  logic [upl_pkg::VAL_W-1:0] out_right_q, out_right_d;
  logic [6:0]                out_count_q, out_count_d;

  // ram port
  logic                       ram_we, ram_re;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [upl_pkg::PAIR_W-1:0] ram_wdata, ram_rdata;

  logic          in_take;
  logic          out_free;
  logic [LW-1:0] level_w, count_w, level_m1;
  logic          level_bad;
  logic [CW-1:0] rd_idx_m1, end_m1, lo_p1, lag_p1;
  logic [PW-1:0] pos_ext;

  upl_ram #(
    .Width(upl_pkg::PAIR_W),
    .Depth(DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_en_i   (ram_re),
    .rd_addr_i (ram_raddr),
    .rd_data_o (ram_rdata)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_take    = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // level range check in a width that holds both level and count
  assign level_w   = LW'(level_i);
  assign count_w   = LW'(count_q);
  assign level_bad = (level_w == '0) || (level_w > count_w);
  assign level_m1  = level_w - LW'(1);

  assign rd_idx_m1 = rd_idx_q - CW'(1);
  assign end_m1    = end_q - CW'(1);
  assign lo_p1     = lo_q + CW'(1);
  assign lag_p1    = CW'(lag_idx_q) + CW'(1);
  assign pos_ext   = PW'(res_pos_q);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    func_d       = func_q;
    key_d        = key_q;
    rd_idx_d     = rd_idx_q;
    lag_v_d      = lag_v_q;
    lag_idx_d    = lag_idx_q;
    lo_d         = lo_q;
    end_d        = end_q;
    phase_d      = phase_q;
    hold_d       = hold_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    res_left_d   = res_left_q;
    res_right_d  = res_right_q;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = '0;

    case (state_q)
      S_IDLE: begin
        if (in_take) begin
          func_d      = func_i;
          key_d       = {tile_left_i, tile_right_i};
          res_pos_d   = '0;
          res_left_d  = '0;
          res_right_d = '0;
          case (func_i)
            upl_pkg::FUNC_INSERT, upl_pkg::FUNC_DELETE: begin
              rd_idx_d = '0;
              lag_v_d  = 1'b0;
              state_d  = S_SRCH;
            end
            upl_pkg::FUNC_READ: begin
              if (level_bad) begin
                res_status_d = upl_pkg::ST_LVL_RANGE;
                state_d      = S_DONE;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = level_m1[AW-1:0];
                res_pos_d = level_m1[AW-1:0];
                state_d   = S_RDLVL;
              end
            end
            default: begin
              // lower half first
              lo_d    = '0;
              end_d   = count_q >> 1;
              phase_d = 1'b0;
              state_d = S_RF_CHK;
            end
          endcase
        end
      end

      S_SRCH: begin
        if (lag_v_q && (ram_rdata == key_q)) begin
          res_pos_d = lag_idx_q;
          if (func_q == upl_pkg::FUNC_INSERT) begin
            res_status_d = upl_pkg::ST_DUPLICATE;
            state_d      = S_DONE;
          end else begin
            // start compaction just above the hit
            rd_idx_d = lag_p1;
            lag_v_d  = 1'b0;
            state_d  = S_SHIFT;
          end
        end else if (rd_idx_q < count_q) begin
          ram_re    = 1'b1;
          ram_raddr = rd_idx_q[AW-1:0];
          lag_v_d   = 1'b1;
          lag_idx_d = rd_idx_q[AW-1:0];
          rd_idx_d  = rd_idx_q + CW'(1);
        end else if (!lag_v_q) begin
          // whole list compared, no hit
          if (func_q == upl_pkg::FUNC_INSERT) begin
            if (count_q == CW'(DEPTH)) begin
              res_status_d = upl_pkg::ST_FULL;
            end else begin
              ram_we       = 1'b1;
              ram_waddr    = count_q[AW-1:0];
              ram_wdata    = key_q;
              res_pos_d    = count_q[AW-1:0];
              res_status_d = upl_pkg::ST_INSERTED;
              count_d      = count_q + CW'(1);
            end
          end else begin
            res_status_d = upl_pkg::ST_NOT_FOUND;
          end
          state_d = S_DONE;
        end else begin
          lag_v_d = 1'b0;
        end
      end

      S_RDLVL: begin
        res_status_d = upl_pkg::ST_FOUND;
        res_left_d   = ram_rdata[upl_pkg::PAIR_W-1:upl_pkg::VAL_W];
        res_right_d  = ram_rdata[upl_pkg::VAL_W-1:0];
        state_d      = S_DONE;
      end

      S_SHIFT: begin
        // entry k+1 read last cycle lands in entry k
        if (lag_v_q) begin
          ram_we    = 1'b1;
          ram_waddr = lag_idx_q;
          ram_wdata = ram_rdata;
        end
        if (rd_idx_q < count_q) begin
          ram_re    = 1'b1;
          ram_raddr = rd_idx_q[AW-1:0];
          lag_v_d   = 1'b1;
          lag_idx_d = rd_idx_m1[AW-1:0];
          rd_idx_d  = rd_idx_q + CW'(1);
        end else begin
          lag_v_d = 1'b0;
          if (!lag_v_q) begin
            count_d      = count_q - CW'(1);
            res_status_d = upl_pkg::ST_DELETED;
            state_d      = S_DONE;
          end
        end
      end

      S_RF_CHK: begin
        if (lo_p1 < end_q) begin
          state_d = S_RF_RDLO;
        end else if (!phase_q) begin
          // upper half
          phase_d = 1'b1;
          lo_d    = count_q >> 1;
          end_d   = count_q;
        end else begin
          res_status_d = upl_pkg::ST_REFLECTED;
          state_d      = S_DONE;
        end
      end

      S_RF_RDLO: begin
        ram_re    = 1'b1;
        ram_raddr = lo_q[AW-1:0];
        state_d   = S_RF_RDHI;
      end

      S_RF_RDHI: begin
        ram_re    = 1'b1;
        ram_raddr = end_m1[AW-1:0];
        hold_d    = ram_rdata;
        state_d   = S_RF_WRLO;
      end

      S_RF_WRLO: begin
        ram_we    = 1'b1;
        ram_waddr = lo_q[AW-1:0];
        ram_wdata = ram_rdata;
        state_d   = S_RF_WRHI;
      end

      S_RF_WRHI: begin
        ram_we    = 1'b1;
        ram_waddr = end_m1[AW-1:0];
        ram_wdata = hold_q;
        lo_d      = lo_p1;
        end_d     = end_m1;
        state_d   = S_RF_CHK;
      end

      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output register: loaded from the pending result once the slot frees up
  always_comb begin
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_pos_d    = out_pos_q;
    out_left_d   = out_left_q;
    out_right_d  = out_right_q;
    out_count_d  = out_count_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == S_DONE) && out_free) begin
      out_valid_d  = 1'b1;
      out_status_d = res_status_q;
      out_pos_d    = pos_ext[upl_pkg::POS_W-1:0];
      out_left_d   = res_left_q;
      out_right_d  = res_right_q;
      out_count_d  = count_w[upl_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      lag_v_q     <= 1'b0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      lag_v_q     <= lag_v_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    key_q        <= key_d;
    rd_idx_q     <= rd_idx_d;
    lag_idx_q    <= lag_idx_d;
    lo_q         <= lo_d;
    end_q        <= end_d;
    hold_q       <= hold_d;
    res_status_q <= res_status_d;
    res_pos_q    <= res_pos_d;
    res_left_q   <= res_left_d;
    res_right_q  <= res_right_d;
    out_status_q <= out_status_d;
    out_pos_q    <= out_pos_d;
    out_left_q   <= out_left_d;
    out_right_q  <= out_right_d;
    out_count_q  <= out_count_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign position_o    = out_pos_q;
  assign out_left_o    = out_left_q;
  assign out_right_o   = out_right_q;
  assign entry_count_o = out_count_q;

  // list never holds more than DEPTH entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above depth");

  // a result word only appears after the sequencer has finished a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result word without finished request");

  // an accepted word always starts work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> (state_q != S_IDLE))
    else $error("accepted word dropped");

  // the count only moves at the end of an insert scan or a compaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      ($past(state_q == S_SRCH) || $past(state_q == S_SHIFT)))
    else $error("entry count changed outside insert or delete");

endmodule
